// ----- rtl/nrmc_pkg.sv -----
package nrmc_pkg;

  // ascii codes seen by the parser
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_W      = 8'h57;

  // header progress codes
  localparam logic [2:0] HDR_LEN  = 3'd6;
  localparam logic [2:0] POS_FAIL = 3'd7;

  // field numbers inside an rmc sentence
  localparam logic [3:0] FIELD_HEADER = 4'd0;
  localparam logic [3:0] FIELD_STATUS = 4'd2;
  localparam logic [3:0] FIELD_LAT    = 4'd3;
  localparam logic [3:0] FIELD_NS     = 4'd4;
  localparam logic [3:0] FIELD_LON    = 4'd5;
  localparam logic [3:0] FIELD_EW     = 4'd6;
  localparam logic [3:0] FIELD_MAX    = 4'd15;

  // per-sentence flags handed from parser to emitter
  typedef struct packed {
    logic status_active;
    logic south;
    logic west;
  } sent_flags_t;

  // expected header text, one character per position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;  // $
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h52;  // R
      3'd4:    ch = 8'h4D;  // M
      3'd5:    ch = 8'h43;  // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/nrmc_parser.sv -----
module nrmc_parser
  import nrmc_pkg::*;
#(
  parameter int FIELD_CHARS = 14,
  localparam int LW = $clog2(FIELD_CHARS + 1),
  localparam int IW = $clog2(FIELD_CHARS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         byte_fire,
  input  logic [7:0]                   rx_byte,
  output logic                         emit_req,
  output sent_flags_t                  flags,
  output logic [LW-1:0]                lat_len,
  output logic [LW-1:0]                lon_len,
  output logic [FIELD_CHARS-1:0][7:0]  lat_text,
  output logic [FIELD_CHARS-1:0][7:0]  lon_text
);

  logic [2:0]    hmp_r, hmp_nxt;
  logic          in_sentence_r, in_sentence_nxt;
  logic          is_rmc_r, is_rmc_nxt;
  logic [3:0]    field_r, field_nxt;
  sent_flags_t   flags_r, flags_nxt;
  logic [LW-1:0] lat_len_r, lat_len_nxt;
  logic [LW-1:0] lon_len_r, lon_len_nxt;
  logic          lat_we, lon_we;
  logic          first;

  logic [FIELD_CHARS-1:0][7:0] lat_text_r;
  logic [FIELD_CHARS-1:0][7:0] lon_text_r;

  always_comb begin
    hmp_nxt         = hmp_r;
    in_sentence_nxt = in_sentence_r;
    is_rmc_nxt      = is_rmc_r;
    field_nxt       = field_r;
    flags_nxt       = flags_r;
    lat_len_nxt     = lat_len_r;
    lon_len_nxt     = lon_len_r;
    lat_we          = 1'b0;
    lon_we          = 1'b0;
    emit_req        = 1'b0;
    first           = (hmp_r == 3'd0);
    if (byte_fire) begin
      if (rx_byte == CHAR_DOLLAR) begin
        // a dollar always restarts, dropping any open sentence
        in_sentence_nxt = 1'b1;
        hmp_nxt         = 3'd1;
        is_rmc_nxt      = 1'b0;
        field_nxt       = FIELD_HEADER;
        flags_nxt       = '0;
        lat_len_nxt     = '0;
        lon_len_nxt     = '0;
      end else if (in_sentence_r) begin
        if (rx_byte == CHAR_CR) begin
          in_sentence_nxt = 1'b0;
          emit_req        = is_rmc_r;
        end else if (rx_byte == CHAR_COMMA) begin
          if (field_r == FIELD_HEADER) begin
            is_rmc_nxt = (hmp_r == HDR_LEN);
          end
          if (field_r != FIELD_MAX) begin
            field_nxt = field_r + 4'd1;
          end
          hmp_nxt = 3'd0;
        end else if (field_r == FIELD_HEADER) begin
          if (hmp_r < HDR_LEN && rx_byte == hdr_char(hmp_r)) begin
            hmp_nxt = hmp_r + 3'd1;
          end else begin
            hmp_nxt = POS_FAIL;
          end
        end else if (is_rmc_r) begin
          // hmp counts characters of the current field, saturating
          if (hmp_r != POS_FAIL) begin
            hmp_nxt = hmp_r + 3'd1;
          end
          case (field_r)
            FIELD_STATUS: flags_nxt.status_active = first && (rx_byte == CHAR_A);
            FIELD_LAT: begin
              if (flags_r.status_active && lat_len_r < LW'(FIELD_CHARS)) begin
                lat_we      = 1'b1;
                lat_len_nxt = lat_len_r + LW'(1);
              end
            end
            FIELD_NS: flags_nxt.south = first && (rx_byte == CHAR_S);
            FIELD_LON: begin
              if (flags_r.status_active && lon_len_r < LW'(FIELD_CHARS)) begin
                lon_we      = 1'b1;
                lon_len_nxt = lon_len_r + LW'(1);
              end
            end
            FIELD_EW: flags_nxt.west = first && (rx_byte == CHAR_W);
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmp_r         <= 3'd0;
      in_sentence_r <= 1'b0;
      is_rmc_r      <= 1'b0;
      field_r       <= FIELD_HEADER;
      flags_r       <= '0;
      lat_len_r     <= '0;
      lon_len_r     <= '0;
    end else begin
      hmp_r         <= hmp_nxt;
      in_sentence_r <= in_sentence_nxt;
      is_rmc_r      <= is_rmc_nxt;
      field_r       <= field_nxt;
      flags_r       <= flags_nxt;
      lat_len_r     <= lat_len_nxt;
      lon_len_r     <= lon_len_nxt;
    end
  end

  // text stores, written in order, only read up to the current length
  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_text_r[lat_len_r[IW-1:0]] <= rx_byte;
    end
    if (lon_we) begin
      lon_text_r[lon_len_r[IW-1:0]] <= rx_byte;
    end
  end

  assign flags    = flags_r;
  assign lat_len  = lat_len_r;
  assign lon_len  = lon_len_r;
  assign lat_text = lat_text_r;
  assign lon_text = lon_text_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lat_len_r <= LW'(FIELD_CHARS) && lon_len_r <= LW'(FIELD_CHARS))
    else $error("coordinate length beyond capacity");

  a_no_text_outside_rmc: assert property (@(posedge clk) disable iff (!rst_n)
    !is_rmc_r |-> (lat_len_r == '0 && lon_len_r == '0))
    else $error("coordinate text captured in a non-rmc sentence");
`endif

endmodule

// ----- rtl/nrmc_emitter.sv -----
module nrmc_emitter
  import nrmc_pkg::*;
#(
  parameter int FIELD_CHARS = 14,
  localparam int LW = $clog2(FIELD_CHARS + 1),
  localparam int IW = $clog2(FIELD_CHARS),
  localparam int TW = $clog2(2 * FIELD_CHARS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  sent_flags_t                  flags,
  input  logic [LW-1:0]                lat_len,
  input  logic [LW-1:0]                lon_len,
  input  logic [FIELD_CHARS-1:0][7:0]  lat_text,
  input  logic [FIELD_CHARS-1:0][7:0]  lon_text,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_fix_valid,
  output logic                         out_coord_select,
  output logic                         out_negative,
  output logic [7:0]                   out_char_code,
  output logic                         out_last_char
);

  logic          busy_r, busy_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic [TW-1:0] total_r;
  logic [LW-1:0] lat_len_r;
  logic          special_r;
  sent_flags_t   flags_r;

  logic [FIELD_CHARS-1:0][7:0] snap_lat_r;
  logic [FIELD_CHARS-1:0][7:0] snap_lon_r;

  logic          out_valid_r, out_valid_nxt;
  logic          fix_r, sel_r, neg_r, last_r;
  logic [7:0]    char_r;

  logic          gen_fire, gen_last, in_lat;
  logic [TW-1:0] lon_idx;
  logic          gen_sel, gen_neg;
  logic [7:0]    gen_char;

  assign gen_fire = busy_r && (!out_valid_r || out_ready);
  assign in_lat   = idx_r < TW'(lat_len_r);
  assign lon_idx  = TW'(idx_r - TW'(lat_len_r));
  assign gen_last = special_r || (idx_r == TW'(total_r - TW'(1)));

  always_comb begin
    if (special_r) begin
      gen_sel  = 1'b0;
      gen_neg  = 1'b0;
      gen_char = 8'h00;
    end else if (in_lat) begin
      gen_sel  = 1'b0;
      gen_neg  = flags_r.south;
      gen_char = snap_lat_r[idx_r[IW-1:0]];
    end else begin
      gen_sel  = 1'b1;
      gen_neg  = flags_r.west;
      gen_char = snap_lon_r[lon_idx[IW-1:0]];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (gen_fire) begin
      idx_nxt = idx_r + TW'(1);
      if (gen_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (gen_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sentence snapshot, frees the parser for the next sentence
  always_ff @(posedge clk) begin
    if (load) begin
      snap_lat_r <= lat_text;
      snap_lon_r <= lon_text;
      lat_len_r  <= lat_len;
      total_r    <= TW'(lat_len) + TW'(lon_len);
      flags_r    <= flags;
      special_r  <= !flags.status_active || (lat_len == '0 && lon_len == '0);
    end
    if (gen_fire) begin
      fix_r  <= flags_r.status_active;
      sel_r  <= gen_sel;
      neg_r  <= gen_neg;
      char_r <= gen_char;
      last_r <= gen_last;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_fix_valid    = fix_r;
  assign out_coord_select = sel_r;
  assign out_negative     = neg_r;
  assign out_char_code    = char_r;
  assign out_last_char    = last_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r)
    else $error("sentence handed over while previous one still draining");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !special_r |-> idx_r < total_r)
    else $error("result index past end of captured text");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    gen_fire && gen_last |=> !busy_r)
    else $error("emitter still busy after final result");
`endif

endmodule

// ----- rtl/nmea_rmc_position_extractor.sv -----
// input channel: in_valid / in_ready / in_rx_byte, one received ascii
// character per transfer. '$' opens a sentence, ',' separates fields and a
// carriage return closes it. only $GPRMC sentences give results.
//
// result channel: out_valid / out_ready plus one port per field. a sentence
// with an active fix gives its latitude characters, then its longitude
// characters, with out_last_char on the final one. an inactive fix gives one
// result with out_fix_valid low.
//
// throughput: one byte per cycle while in_ready is high. the parser updates
// its state at each accepted byte; a closing carriage return copies the
// captured text into the emitter, which drains one result per cycle from
// its output register while out_ready is high. the carriage return's
// transfer loads the snapshot, then the output register takes each result.
// stalls: while the emitter still drains a sentence, a further carriage
// return waits (in_ready low for it); every other byte keeps flowing. a
// stalled receiver holds the output register and the drain pauses.
// reset: rst_n is synchronous; the block comes up outside any sentence with
// no result pending.
module nmea_rmc_position_extractor
  import nrmc_pkg::*;
#(
  parameter int FIELD_CHARS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_fix_valid,
  output logic       out_coord_select,
  output logic       out_negative,
  output logic [7:0] out_char_code,
  output logic       out_last_char
);

  localparam int LW = $clog2(FIELD_CHARS + 1);

  logic                         byte_fire;
  logic                         emit_req;
  logic                         emit_busy;
  sent_flags_t                  flags;
  logic [LW-1:0]                lat_len;
  logic [LW-1:0]                lon_len;
  logic [FIELD_CHARS-1:0][7:0]  lat_text;
  logic [FIELD_CHARS-1:0][7:0]  lon_text;

  // only a sentence end has to wait for the emitter's snapshot to be free
  assign in_ready  = !emit_busy || (in_rx_byte != CHAR_CR);
  assign byte_fire = in_valid && in_ready;

  // per-byte sentence state and text capture
  nrmc_parser #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(byte_fire),
    .rx_byte  (in_rx_byte),
    .emit_req (emit_req),
    .flags    (flags),
    .lat_len  (lat_len),
    .lon_len  (lon_len),
    .lat_text (lat_text),
    .lon_text (lon_text)
  );

  // snapshot of a finished sentence, drained one result per transfer
  nrmc_emitter #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (emit_req),
    .flags           (flags),
    .lat_len         (lat_len),
    .lon_len         (lon_len),
    .lat_text        (lat_text),
    .lon_text        (lon_text),
    .busy            (emit_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fix_valid   (out_fix_valid),
    .out_coord_select(out_coord_select),
    .out_negative    (out_negative),
    .out_char_code   (out_char_code),
    .out_last_char   (out_last_char)
  );

endmodule
